[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Needs nothing else; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is low.
`define ASSERT_CLKD(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/bsfb_pkg.sv]
// Types and constants of the byte stuffing frame builder.
// Used by the core and by its checker; depends on nothing.
package bsfb_pkg;

  // One request on the item channel.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_payload;
    logic       sequence_bit;
  } bsfb_item_t;

  // One request on the result channel.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } bsfb_result_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FLAG     = 3'd0;
  localparam logic [2:0] CFG_ESCAPE   = 3'd1;
  localparam logic [2:0] CFG_ADDRESS  = 3'd2;
  localparam logic [2:0] CFG_CTRL_ZERO = 3'd3;
  localparam logic [2:0] CFG_CTRL_ONE = 3'd4;

  // Configuration reset values.
  localparam logic [7:0] FLAG_RESET      = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET    = 8'h7D;
  localparam logic [7:0] ADDRESS_RESET   = 8'h03;
  localparam logic [7:0] CTRL_ZERO_RESET = 8'h00;
  localparam logic [7:0] CTRL_ONE_RESET  = 8'h40;

  // Value XORed into a byte that follows the escape byte.
  localparam logic [7:0] STUFF_MASK = 8'h20;

  // Output sequencer steps, one-hot.
  typedef enum logic [8:0] {
    PH_FLAG   = 9'b000000001,
    PH_ADDR   = 9'b000000010,
    PH_CTRL   = 9'b000000100,
    PH_BCC1   = 9'b000001000,
    PH_DATA   = 9'b000010000,
    PH_DATA_X = 9'b000100000,
    PH_BCC2   = 9'b001000000,
    PH_BCC2_X = 9'b010000000,
    PH_CLOSE  = 9'b100000000
  } bsfb_phase_t;

endpackage

[rtl/byte_stuffing_frame_builder_core.sv]
// Top level of the byte stuffing frame builder: HDLC-style framer core.
// Depends on bsfb_pkg for the channel structs, register indexes and sequencer codes.
//
// Usage
// The item channel (item_valid / item_ready / item) carries one payload byte per
// request, with an end-of-payload mark and the sequence bit. The result channel
// (result_valid / result_ready / result) carries one line byte per request.
// The first item of a frame produces the opening flag, address, control byte and
// BCC1 ahead of its payload byte; a payload byte equal to the flag or the escape
// value goes out as the escape byte and the byte XOR 0x20. The item marked last
// also produces BCC2 (stuffed the same way) and the closing flag, which carries
// frame_done. run_last marks the final result of each item.
// The first result of an item passes through the item register and then the
// output register. Throughput is one result byte per cycle while the receiver
// does not stall, set by the single output register: an unstuffed mid-frame
// byte gives one result, a stuffed byte two, and a frame start or frame end adds
// four or two to three. An item is taken in the same cycle its predecessor's last
// byte moves into the output register, so the next request need not wait for it to drain.
// When the receiver stalls, the output register holds its byte and the sequencer
// and item register wait. Synchronous reset empties both registers, closes any
// open frame, clears BCC2 and loads the default register values. The user must write
// configuration (cfg_we / cfg_index / cfg_data) only while idle; not enforced by the core.
module byte_stuffing_frame_builder_core
  import bsfb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  bsfb_item_t   item,
  output logic         result_valid,
  input  logic         result_ready,
  output bsfb_result_t result,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  // Configuration registers.
  logic [7:0] flag_value;
  logic [7:0] escape_value;
  logic [7:0] address_value;
  logic [7:0] control_seq_zero;
  logic [7:0] control_seq_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_value       <= FLAG_RESET;
      escape_value     <= ESCAPE_RESET;
      address_value    <= ADDRESS_RESET;
      control_seq_zero <= CTRL_ZERO_RESET;
      control_seq_one  <= CTRL_ONE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLAG:      flag_value       <= cfg_data;
        CFG_ESCAPE:    escape_value     <= cfg_data;
        CFG_ADDRESS:   address_value    <= cfg_data;
        CFG_CTRL_ZERO: control_seq_zero <= cfg_data;
        CFG_CTRL_ONE:  control_seq_one  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item register and sequencer state. frame_open tracks whether a frame is
  // open after every item accepted so far, so the start decision for a new
  // item never waits on the bytes still draining from the previous one.
  bsfb_item_t  work;
  logic        busy;
  bsfb_phase_t phase;
  bsfb_phase_t phase_next;
  logic        frame_open;
  logic [7:0]  payload_xor;

  logic       accept;
  logic       emit;
  logic       emit_final;
  logic       emit_done;
  logic [7:0] emit_byte;
  logic [7:0] ctrl_byte;
  logic       data_needs_esc;
  logic       bcc_needs_esc;

  assign ctrl_byte      = work.sequence_bit ? control_seq_one : control_seq_zero;
  assign data_needs_esc = (work.payload_byte == flag_value) ||
                          (work.payload_byte == escape_value);
  assign bcc_needs_esc  = (payload_xor == flag_value) || (payload_xor == escape_value);

  // While busy, a byte moves into the output register whenever it is empty or being drained.
  assign emit       = busy && (!result_valid || result_ready);
  assign item_ready = !busy || (emit && emit_final);
  assign accept     = item_valid && item_ready;

  // Byte selection for the current step. BCC2 uses payload_xor, which already
  // includes this item's byte because the data step folded it in.
  always_comb begin
    emit_byte  = flag_value;
    emit_final = 1'b0;
    emit_done  = 1'b0;
    phase_next = phase;
    case (phase)
      PH_FLAG: begin
        emit_byte  = flag_value;
        phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        emit_byte  = address_value;
        phase_next = PH_CTRL;
      end
      PH_CTRL: begin
        emit_byte  = ctrl_byte;
        phase_next = PH_BCC1;
      end
      PH_BCC1: begin
        emit_byte  = address_value ^ ctrl_byte;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        if (data_needs_esc) begin
          emit_byte  = escape_value;
          phase_next = PH_DATA_X;
        end else begin
          emit_byte  = work.payload_byte;
          emit_final = !work.end_of_payload;
          phase_next = PH_BCC2;
        end
      end
      PH_DATA_X: begin
        emit_byte  = work.payload_byte ^ STUFF_MASK;
        emit_final = !work.end_of_payload;
        phase_next = PH_BCC2;
      end
      PH_BCC2: begin
        if (bcc_needs_esc) begin
          emit_byte  = escape_value;
          phase_next = PH_BCC2_X;
        end else begin
          emit_byte  = payload_xor;
          phase_next = PH_CLOSE;
        end
      end
      PH_BCC2_X: begin
        emit_byte  = payload_xor ^ STUFF_MASK;
        phase_next = PH_CLOSE;
      end
      PH_CLOSE: begin
        emit_byte  = flag_value;
        emit_final = 1'b1;
        emit_done  = 1'b1;
        phase_next = PH_CLOSE;
      end
      default: begin
        emit_byte  = flag_value;
        phase_next = PH_CLOSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      phase      <= PH_FLAG;
      frame_open <= 1'b0;
    end else if (accept) begin
      busy       <= 1'b1;
      phase      <= frame_open ? PH_DATA : PH_FLAG;
      frame_open <= !item.end_of_payload;
    end else if (emit) begin
      busy  <= !emit_final;
      phase <= phase_next;
    end
  end

  // Running BCC2: cleared when a new frame is accepted, folded on the data step.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_xor <= 8'h00;
    end else if (accept && !frame_open) begin
      payload_xor <= 8'h00;
    end else if (emit && (phase == PH_DATA)) begin
      payload_xor <= payload_xor ^ work.payload_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work <= item;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.line_byte  <= emit_byte;
      result.run_last   <= emit_final;
      result.frame_done <= emit_done;
    end
  end

endmodule

[rtl/bsfb_checker.sv]
// Port-level assertions for the byte stuffing frame builder core, plus its bind.
// Depends on bsfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsfb_checker
  import bsfb_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         item_valid,
  input logic         item_ready,
  input logic         result_valid,
  input logic         result_ready,
  input bsfb_result_t result,
  input logic         cfg_we
);

  // A stalled result keeps its byte and marks.
  `ASSERT_CLKD(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result))

  // The closing flag is always the final result of its item.
  `ASSERT_CLKD(a_done_is_last, clk, rst, result_valid && result.frame_done |-> result.run_last)

  // Reset leaves the result channel empty.
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid)

  // Configuration writes only come while no item is offered and no result waits.
  `ASSERT_CLKD(a_cfg_idle, clk, rst, cfg_we |-> !item_valid && !result_valid)

endmodule

bind byte_stuffing_frame_builder_core bsfb_checker u_bsfb_checker (.*);
